### hw/rtl/cgtg_pkg.sv
// Shared types, constants and the glow table builder for the cubemap gradient texel generator.
package cgtg_pkg;

  localparam int FACE_SIZE_DEF = 128;
  localparam int GLOW_ENTRIES = 1024;
  localparam int GLOW_W = 17;
  localparam int MAG_W = 17;
  localparam int VAL_W = 21;
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;

  typedef enum logic [2:0] {
    REG_SKY     = 3'd0,
    REG_HORIZON = 3'd1,
    REG_FLOOR   = 3'd2,
    REG_FLOOR_EN = 3'd3,
    REG_GLOW    = 3'd4
  } cfg_reg_t;

  localparam logic [47:0] COLOR_RST = 48'd0;
  localparam logic FLOOR_EN_RST = 1'b1;
  localparam logic [15:0] GLOW_GAIN_RST = 16'd2458;

  typedef struct packed {
    logic [47:0] sky;
    logic [47:0] horizon;
    logic [47:0] floor_c;
    logic        floor_en;
    logic [15:0] gain;
  } cgtg_cfg_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } cgtg_dir_t;

  typedef logic [GLOW_W-1:0] glow_rom_t [GLOW_ENTRIES];

  function automatic glow_rom_t glow_rom_build();
    glow_rom_t rom;
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] r;
    longint sum;
    for (int i = 0; i < GLOW_ENTRIES; i++) begin
      x = (64'(i) * 64'(i) * 64'd1280000) / 64'd9;
      n = x >> 32;
      f = x & 64'hffff_ffff;
      if (n >= 64'd40) begin
        rom[i] = '0;
      end else begin
        sum = 64'sd1 <<< 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 20; k++) begin
          term = ((term * f) >> 32) / 64'(k);
          if ((k & 1) == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        r = 64'(sum);
        while (n > 0) begin
          r = (r * EXP_M1_Q32) >> 32;
          n = n - 64'd1;
        end
        rom[i] = GLOW_W'((r + 64'd32768) >> 16);
      end
    end
    return rom;
  endfunction

endpackage

### hw/rtl/cgtg_dir.sv
// Direction pipeline: texel address to the magnitude of the normalized vertical component.
module cgtg_dir
  import cgtg_pkg::*;
#(
  parameter int FACE_SIZE = FACE_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_vld,
  input  logic [2:0] face,
  input  logic [6:0] col,
  input  logic [6:0] row,
  output cgtg_dir_t dout
);

  localparam int NW = $clog2(FACE_SIZE + 1);
  localparam int LW = $clog2(3 * FACE_SIZE * FACE_SIZE);
  localparam int XW = LW + 32;
  localparam int XW2 = XW + (XW % 2);
  localparam int RW = XW2 / 2;
  localparam int DW = NW + 32;
  localparam int QW = MAG_W;

  logic [NW-1:0] cs, rsat, aab, bab, sabs;
  logic signed [NW+1:0] a, b;
  logic [LW-1:0] l;
  logic neg;

  always_comb begin
    cs = ({{NW{1'b0}}, col} > (NW+7)'(FACE_SIZE - 1)) ? NW'(FACE_SIZE - 1) : NW'(col);
    rsat = ({{NW{1'b0}}, row} > (NW+7)'(FACE_SIZE - 1)) ? NW'(FACE_SIZE - 1) : NW'(row);
    a = $signed(({2'b0, cs} << 1) + (NW+2)'(1) - (NW+2)'(FACE_SIZE));
    b = $signed(({2'b0, rsat} << 1) + (NW+2)'(1) - (NW+2)'(FACE_SIZE));
    aab = a[NW+1] ? NW'(-a) : NW'(a);
    bab = b[NW+1] ? NW'(-b) : NW'(b);
    l = LW'(FACE_SIZE * FACE_SIZE) + LW'({{NW{1'b0}}, aab} * {{NW{1'b0}}, aab})
      + LW'({{NW{1'b0}}, bab} * {{NW{1'b0}}, bab});
    if (face == FACE_PY) begin
      neg = 1'b0;
      sabs = NW'(FACE_SIZE);
    end else if (face == FACE_NY) begin
      neg = 1'b1;
      sabs = NW'(FACE_SIZE);
    end else begin
      neg = !b[NW+1] && (b != '0);
      sabs = bab;
    end
  end

  logic          sq_vld  [0:RW];
  logic [LW-1:0] sq_l    [0:RW];
  logic [RW+1:0] sq_rem  [0:RW];
  logic [RW-1:0] sq_root [0:RW];
  logic [NW-1:0] sq_s    [0:RW];
  logic          sq_neg  [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_l[0] <= l;
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      sq_s[0] <= sabs;
      sq_neg[0] <= neg;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [XW2-1:0] xf;
    logic [1:0] pr;
    logic [RW+1:0] rsh, trial;
    assign xf = XW2'(sq_l[j]) << 32;
    assign pr = xf[XW2-1-2*j -: 2];
    assign rsh = {sq_rem[j][RW-1:0], pr};
    assign trial = {sq_root[j], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[j+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[j+1] <= sq_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_l[j+1] <= sq_l[j];
        sq_s[j+1] <= sq_s[j];
        sq_neg[j+1] <= sq_neg[j];
        if (rsh >= trial) begin
          sq_rem[j+1] <= rsh - trial;
          sq_root[j+1] <= {sq_root[j][RW-2:0], 1'b1};
        end else begin
          sq_rem[j+1] <= rsh;
          sq_root[j+1] <= {sq_root[j][RW-2:0], 1'b0};
        end
      end
    end
  end

  logic          dv_vld [0:QW];
  logic [DW-1:0] dv_rem [0:QW];
  logic [RW-1:0] dv_r   [0:QW];
  logic [QW-1:0] dv_q   [0:QW];
  logic          dv_neg [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= sq_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= {sq_s[RW], 32'd0};
      dv_r[0] <= sq_root[RW];
      dv_q[0] <= '0;
      dv_neg[0] <= sq_neg[RW];
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [DW+1:0] sub;
    logic take;
    assign sub = (DW+2)'(dv_r[i]) << (QW - 1 - i);
    assign take = {2'b00, dv_rem[i]} >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[i+1] <= dv_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[i+1] <= dv_r[i];
        dv_neg[i+1] <= dv_neg[i];
        dv_q[i+1] <= {dv_q[i][QW-2:0], take};
        dv_rem[i+1] <= take ? DW'({2'b00, dv_rem[i]} - sub) : dv_rem[i];
      end
    end
  end

  assign dout.vld = dv_vld[QW];
  assign dout.neg = dv_neg[QW];
  assign dout.mag = (dv_q[QW] > QW'(65536)) ? QW'(65536) : dv_q[QW];

endmodule

### hw/rtl/cgtg_shade.sv
// Shading pipeline: smoothstep blend, horizon glow and binary16 packing of the three channels.
module cgtg_shade
  import cgtg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  cgtg_dir_t din,
  input  cgtg_cfg_t cfg,
  output logic      out_vld,
  output logic [47:0] out_data
);

  localparam glow_rom_t GLOW_ROM = glow_rom_build();

  function automatic logic [4:0] lead_one(input logic [VAL_W-1:0] v);
    logic [4:0] p;
    p = '0;
    for (int k = 0; k < VAL_W; k++) begin
      if (v[k]) p = 5'(k);
    end
    return p;
  endfunction

  function automatic logic [15:0] to_half(input logic [VAL_W-1:0] v, input logic [4:0] p);
    logic [21:0] mm;
    logic [VAL_W-1:0] rm, hf;
    logic [5:0] e;
    logic [15:0] res;
    e = {1'b0, p};
    mm = '0;
    rm = '0;
    hf = '0;
    if (v == '0) begin
      res = '0;
    end else if (p == 5'd0) begin
      res = 16'h0200;
    end else begin
      if (p >= 5'd10) begin
        mm = 22'(v >> (p - 5'd10));
        rm = v & ((VAL_W'(1) << (p - 5'd10)) - VAL_W'(1));
        if (p > 5'd10) begin
          hf = VAL_W'(1) << (p - 5'd11);
          if (rm > hf || (rm == hf && mm[0])) mm = mm + 22'd1;
        end
      end else begin
        mm = 22'(v) << (5'd10 - p);
      end
      if (mm >= 22'd2048) begin
        mm = mm >> 1;
        e = e + 6'd1;
      end
      res = {e[5:0], mm[9:0]};
    end
    return res;
  endfunction

  logic [15:0] hcol [3];
  logic [15:0] scol [3];
  logic [15:0] fcol [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hcol[c] = cfg.horizon[47-16*c -: 16];
      scol[c] = cfg.sky[47-16*c -: 16];
      fcol[c] = cfg.floor_c[47-16*c -: 16];
    end
  end

  logic [6:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:0], din.vld};
    end
  end

  logic lower1, lower2, lower3;
  logic [16:0] t1, t2;
  logic [GLOW_W-1:0] g1, g2;
  logic [32:0] tt2;
  logic [16:0] w3;
  logic [16:0] hg3 [3];
  logic [32:0] pm4 [3];
  logic [32:0] pc4 [3];
  logic [32:0] pg4 [3];
  logic [VAL_W-1:0] val5 [3];
  logic [VAL_W-1:0] val6 [3];
  logic [4:0] p6 [3];
  logic [15:0] half7 [3];

  logic lower0;
  logic [16:0] t0;
  logic [11:0] idx0;
  always_comb begin
    lower0 = cfg.floor_en && din.neg;
    if (lower0) t0 = din.mag;
    else if (din.neg) t0 = 17'((18'd65536 - 18'(din.mag)) >> 1);
    else t0 = 17'((18'd65536 + 18'(din.mag)) >> 1);
    idx0 = 12'((18'(din.mag) + 18'd16) >> 5);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lower1 <= lower0;
      t1 <= t0;
      g1 <= (idx0 >= 12'(GLOW_ENTRIES)) ? '0 : GLOW_ROM[idx0[9:0]];

      lower2 <= lower1;
      t2 <= t1;
      g2 <= g1;
      tt2 <= 33'(34'(t1) * 34'(t1));

      lower3 <= lower2;
      w3 <= 17'((51'(tt2) * 51'(18'd196608 - 18'({t2, 1'b0}))) >> 32);
      for (int c = 0; c < 3; c++) begin
        hg3[c] <= 17'((33'(hcol[c]) * 33'(g2) + 33'd32768) >> 16);
      end

      for (int c = 0; c < 3; c++) begin
        pm4[c] <= 33'(hcol[c]) * 33'(17'd65536 - w3);
        pc4[c] <= 33'(lower3 ? fcol[c] : scol[c]) * 33'(w3);
        pg4[c] <= 33'(hg3[c]) * 33'(cfg.gain);
      end

      for (int c = 0; c < 3; c++) begin
        val5[c] <= VAL_W'((34'(pm4[c]) + 34'(pc4[c]) + 34'd32768) >> 16)
                 + VAL_W'((34'(pg4[c]) + 34'd4096) >> 13);
      end

      for (int c = 0; c < 3; c++) begin
        val6[c] <= val5[c];
        p6[c] <= lead_one(val5[c]);
      end

      for (int c = 0; c < 3; c++) begin
        half7[c] <= to_half(val6[c], p6[c]);
      end
    end
  end

  assign out_vld = vld[6];
  assign out_data = {half7[2], half7[1], half7[0]};

endmodule

### hw/rtl/cubemap_gradient_texel_gen.sv
// Top level of the cubemap gradient texel generator: stream ports, configuration and pipeline.
//
// Each accepted texel address yields one fp16 RGB texel. The block takes a new transaction every
// cycle unless the output stalls. The square root takes R steps, R being half the even-rounded
// width of (3 * FACE_SIZE^2) << 32 (24 for a face size of 128). The depth of the pipeline comes
// from the one-bit-per-stage square root and the 17-stage restoring divider that normalize the
// direction. When the output is not taken, the whole pipeline holds. Configuration writes are
// always accepted and must only happen while no texel is in flight.
module cubemap_gradient_texel_gen
  import cgtg_pkg::*;
#(
  parameter int FACE_SIZE = FACE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // face_index [2:0], texel_column [9:3], texel_row [16:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // red_half [15:0], green_half [31:16], blue_half [47:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cgtg_cfg_t cfg;
  cgtg_dir_t dir;
  logic adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sky <= COLOR_RST;
      cfg.horizon <= COLOR_RST;
      cfg.floor_c <= COLOR_RST;
      cfg.floor_en <= FLOOR_EN_RST;
      cfg.gain <= GLOW_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SKY:      cfg.sky <= cfg_data;
        REG_HORIZON:  cfg.horizon <= cfg_data;
        REG_FLOOR:    cfg.floor_c <= cfg_data;
        REG_FLOOR_EN: cfg.floor_en <= cfg_data[0];
        REG_GLOW:     cfg.gain <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  cgtg_dir #(
    .FACE_SIZE(FACE_SIZE)
  ) u_dir (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .in_vld(s_axis_tvalid),
    .face  (s_axis_tdata[2:0]),
    .col   (s_axis_tdata[9:3]),
    .row   (s_axis_tdata[16:10]),
    .dout  (dir)
  );

  cgtg_shade u_shade (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .din     (dir),
    .cfg     (cfg),
    .out_vld (m_axis_tvalid),
    .out_data(m_axis_tdata)
  );

endmodule
